// ----- rtl/core/b64_pkg.sv -----
// Shared types, constants and character-table functions for the Base64 stream codec.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package b64_pkg;

	// Configuration register indexes.
	localparam logic CFG_MODE        = 1'b0;
	localparam logic CFG_LINE_LENGTH = 1'b1;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [7:0] CHAR_PAD        = 8'h3D;
	localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
	localparam logic [7:0] CHAR_PLUS       = 8'h2B;
	localparam logic [7:0] CHAR_SLASH      = 8'h2F;
	localparam logic [7:0] PRINTABLE_LOW   = 8'd32;
	localparam logic [7:0] PRINTABLE_HIGH  = 8'd126;

	localparam int MAX_CHARS = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic       out_error;
		logic       out_last;
	} result_t;

	// One accepted item after classification: the characters it produces, before
	// line breaks are inserted.
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [2:0]                count;
		logic                      text;
		logic                      last;
		logic                      error;
	} desc_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
		logic [7:0] r;
		begin
			r = 8'd0;
			if (s < 6'd26) begin
				r = 8'h41 + {2'b00, s};
			end else if (s < 6'd52) begin
				r = 8'h61 + {2'b00, s - 6'd26};
			end else if (s < 6'd62) begin
				r = 8'h30 + {2'b00, s - 6'd52};
			end else if (s == 6'd62) begin
				r = CHAR_PLUS;
			end else begin
				r = CHAR_SLASH;
			end
			return r;
		end
	endfunction

	function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd63;
			if (c >= 8'h41 && c <= 8'h5A) begin
				t = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				t = c - 8'h61 + 8'd26;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30 + 8'd52;
			end else if (c == CHAR_PLUS) begin
				t = 8'd62;
			end
			return t[5:0];
		end
	endfunction

endpackage

// ----- rtl/core/b64_front.sv -----
// Front end: accepts input bytes, packs or unpacks bits and produces at most one request per item.
// Depends on b64_pkg; feeds b64_queue.
`timescale 1ns / 1ps

module b64_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mode,
	input  logic            push,
	output logic            full,
	input  b64_pkg::item_t  item,
	input  logic            queue_full,
	output logic            desc_push,
	output b64_pkg::desc_t  desc
);
	import b64_pkg::*;

	logic [11:0] buffer_q;
	logic [3:0]  count_q;
	logic [1:0]  phase_q;
	logic        error_q;

	logic [11:0] buffer_n;
	logic [3:0]  count_n;
	logic [1:0]  phase_n;
	logic        error_n;
	logic        accept;

	assign full   = queue_full;
	assign accept = push && !queue_full;

	always_comb begin
		logic [3:0]  bc;
		logic [11:0] bb;
		logic [11:0] nb;
		logic [3:0]  bcn;
		logic [11:0] sh;
		logic [11:0] mask;
		logic [1:0]  pads;
		logic [2:0]  n;
		logic [7:0]  c;

		desc       = '0;
		buffer_n   = buffer_q;
		count_n    = count_q;
		phase_n    = phase_q;
		error_n    = error_q | item.in_byte[7];
		n          = 3'd0;
		bc         = 4'd0;
		bb         = 12'd0;
		nb         = 12'd0;
		bcn        = 4'd0;
		sh         = 12'd0;
		mask       = 12'd0;
		pads       = 2'd0;
		c          = 8'd0;

		if (mode == MODE_ENCODE) begin
			bc  = (count_q > 4'd4) ? 4'd4 : count_q;
			bb  = (count_q > 4'd4) ? (buffer_q & 12'h00F) : buffer_q;
			nb  = {bb[3:0], item.in_byte};
			bcn = bc + 4'd8;
			// First sextet always exists, since at least eight bits are pending.
			sh  = nb >> (bcn - 4'd6);
			desc.chars[0] = sextet_to_char(sh[5:0]);
			n   = 3'd1;
			bcn = bcn - 4'd6;
			if (bcn >= 4'd6) begin
				sh  = nb >> (bcn - 4'd6);
				desc.chars[1] = sextet_to_char(sh[5:0]);
				n   = 3'd2;
				bcn = bcn - 4'd6;
			end
			mask     = (12'd1 << bcn) - 12'd1;
			buffer_n = nb & mask;
			count_n  = bcn;
			phase_n  = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
			if (item.in_last) begin
				pads = (phase_n == 2'd1) ? 2'd2 : ((phase_n == 2'd2) ? 2'd1 : 2'd0);
				if (bcn != 4'd0) begin
					sh = buffer_n << (4'd6 - bcn);
					c  = sextet_to_char(sh[5:0]);
					if (n < 3'd4) begin
						desc.chars[n[1:0]] = c;
					end
					n = n + 3'd1;
				end
				if (pads != 2'd0) begin
					if (n < 3'd4) begin
						desc.chars[n[1:0]] = CHAR_PAD;
					end
					n = n + 3'd1;
				end
				if (pads == 2'd2) begin
					if (n < 3'd4) begin
						desc.chars[n[1:0]] = CHAR_PAD;
					end
					n = n + 3'd1;
				end
			end
			desc.text = 1'b1;
		end else if (item.in_byte != CHAR_NEWLINE && item.in_byte != CHAR_PAD) begin
			bc  = (count_q > 4'd6) ? 4'd6 : count_q;
			bb  = (count_q > 4'd6) ? (buffer_q & 12'h03F) : buffer_q;
			nb  = {bb[5:0], char_to_sextet(item.in_byte)};
			bcn = bc + 4'd6;
			if (bcn >= 4'd8) begin
				sh  = nb >> (bcn - 4'd8);
				bcn = bcn - 4'd8;
				if (sh[7:0] >= PRINTABLE_LOW && sh[7:0] <= PRINTABLE_HIGH) begin
					desc.chars[0] = sh[7:0];
					n = 3'd1;
				end
			end
			mask     = (12'd1 << bcn) - 12'd1;
			buffer_n = nb & mask;
			count_n  = bcn;
		end

		desc.count = n;
		desc.last  = item.in_last;
		desc.error = error_n;
		desc_push  = accept && (n != 3'd0 || item.in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q <= '0;
			count_q  <= '0;
			phase_q  <= '0;
			error_q  <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				buffer_q <= '0;
				count_q  <= '0;
				phase_q  <= '0;
				error_q  <= 1'b0;
			end else begin
				buffer_q <= buffer_n;
				count_q  <= count_n;
				phase_q  <= phase_n;
				error_q  <= error_n;
			end
		end
	end

endmodule

// ----- rtl/core/b64_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on b64_pkg for the request type.
`timescale 1ns / 1ps

module b64_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  b64_pkg::desc_t  wr_data,
	output logic            full,
	input  logic            rd_en,
	output b64_pkg::desc_t  rd_data,
	output logic            empty
);
	import b64_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	desc_t           slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (fill_q == CntW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/b64_back.sv -----
// Back end: expands each request into results, inserts line breaks, and holds the output register.
// Depends on b64_pkg; reads requests from b64_queue.
`timescale 1ns / 1ps

module b64_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [9:0]        line_length,
	input  logic              queue_empty,
	input  b64_pkg::desc_t    desc,
	output logic              queue_pop,
	output logic              empty,
	input  logic              pop,
	output b64_pkg::result_t  result
);
	import b64_pkg::*;

	result_t    out_q;
	logic       out_valid_q;
	logic [2:0] idx_q;
	logic       nl_pending_q;
	logic [9:0] line_q;

	result_t    res;
	logic       emit;
	logic [2:0] idx_n;
	logic       nl_pending_n;
	logic [9:0] line_n;
	logic       slot_free;

	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign slot_free = !out_valid_q || pop;

	always_comb begin
		logic [10:0] next_count;
		logic        need_nl;
		logic        done;

		res          = '0;
		emit         = 1'b0;
		queue_pop    = 1'b0;
		idx_n        = idx_q;
		nl_pending_n = nl_pending_q;
		line_n       = line_q;
		next_count   = {1'b0, line_q} + 11'd1;
		need_nl      = 1'b0;
		done         = 1'b0;

		if (!queue_empty && slot_free) begin
			priority if (nl_pending_q) begin
				done          = (idx_q == desc.count);
				res.out_char  = CHAR_NEWLINE;
				res.out_valid = 1'b1;
				res.out_error = desc.error;
				res.out_last  = desc.last && done;
				emit          = 1'b1;
				nl_pending_n  = 1'b0;
			end else if (idx_q < desc.count) begin
				res.out_char  = desc.chars[idx_q[1:0]];
				res.out_valid = 1'b1;
				res.out_error = desc.error;
				emit          = 1'b1;
				if (desc.text) begin
					if (line_length == 10'd0) begin
						line_n = 10'd0;
					end else if (next_count >= {1'b0, line_length}) begin
						need_nl = 1'b1;
						line_n  = 10'd0;
					end else begin
						line_n = next_count[9:0];
					end
				end
				idx_n        = idx_q + 3'd1;
				nl_pending_n = need_nl;
				done         = (idx_n == desc.count) && !need_nl;
				res.out_last = desc.last && done;
			end else begin
				// Nothing to give for this item: the end of a message still closes with
				// an empty result.
				done = 1'b1;
				if (desc.last) begin
					res.out_error = desc.error;
					res.out_last  = 1'b1;
					emit          = 1'b1;
				end
			end
			if (done) begin
				queue_pop = 1'b1;
				idx_n     = 3'd0;
				if (desc.last) begin
					line_n = 10'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			nl_pending_q <= 1'b0;
			line_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			idx_q        <= idx_n;
			nl_pending_q <= nl_pending_n;
			line_q       <= line_n;
		end
	end

endmodule

// ----- rtl/core/base64_stream_codec.sv -----
// Channel    | Handshake            | Payload
// input      | push / full          | item   (in_byte, in_last)
// result     | empty / pop          | result (out_char, out_valid, out_error, out_last)
// config     | cfg_write            | cfg_index, cfg_data
//
// An item is taken in the cycle it is pushed whenever the request queue has room.
// The back end gives one result per cycle while its output register is free or popped;
// an item gives at most eight results: four characters, each followed by a line break.
// Encoding averages four characters per three bytes.
// Reset clears all control state at once; no clearing pass is needed.
// Either side may stall: the queue and the output register hold the work in between.
//
// Top level of the Base64 stream codec: configuration registers and the three parts.
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
`timescale 1ns / 1ps

module base64_stream_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  b64_pkg::item_t    item,
	output logic              empty,
	input  logic              pop,
	output b64_pkg::result_t  result,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [9:0]        cfg_data
);
	import b64_pkg::*;

	logic       mode_q;
	logic [9:0] line_length_q;

	logic  q_full;
	logic  q_empty;
	logic  q_push;
	logic  q_pop;
	desc_t q_wr_data;
	desc_t q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCODE;
			line_length_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MODE:        mode_q        <= cfg_data[0];
				CFG_LINE_LENGTH: line_length_q <= cfg_data;
				default:         mode_q        <= mode_q;
			endcase
		end
	end

	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.push       (push),
		.full       (full),
		.item       (item),
		.queue_full (q_full),
		.desc_push  (q_push),
		.desc       (q_wr_data)
	);

	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	b64_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (line_length_q),
		.queue_empty (q_empty),
		.desc        (q_rd_data),
		.queue_pop   (q_pop),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule
